/* rtl/lccp_pkg.sv */
// Shared types and constants for the light cue color player.
// No dependencies.
package lccp_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam int TIME_W  = 32;
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    // entry: start, duration, color, prior color, fade, sets-color
    localparam int ENTRY_W = 2 * TIME_W + 2 * COLOR_W + 2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TIME_W-1:0] time_ms;
        logic [TIME_W-1:0] event_duration_ms;
        logic [CHAN_W-1:0] event_red;
        logic [CHAN_W-1:0] event_green;
        logic [CHAN_W-1:0] event_blue;
        logic              event_sets_color;
        logic              event_is_fade;
    } req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              out_of_program;
    } rsp_t;

    typedef struct packed {
        logic [TIME_W-1:0]  start;
        logic [TIME_W-1:0]  dur;
        logic [COLOR_W-1:0] color;
        logic [COLOR_W-1:0] prior;
        logic               fade;
        logic               sets;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;      // wipe list state
        logic append;     // write the captured request into the table
        logic capture;    // latch the incoming request
        logic emit;       // copy the finished result into the output register
        logic probe_eval; // evaluate read data against the query time
        logic probe_next; // advance probe index
        logic mul_start;  // load blend operands
        logic mul_step;   // form products for one channel
        logic div_start;  // start the divider on one channel
        logic ch_store;   // store divider quotient into the result
        logic load_oop;   // result is black / out of program
        logic load_plain; // result is a flat color
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
        logic is_append;
        logic is_clear;
        logic oop;        // empty list or past program end
        logic hit;        // probe holds the query time
        logic probe_last; // no further probe candidates
        logic blend;      // selected event fades
        logic div_done;
        logic ch_last;    // third channel handled
    } stat_t;

endpackage

/* rtl/light_cue_color_player_unit.sv */
// Light cue color player: stores a cue list and plays back color at a show time.
// Appends and clears give no result. A query that is out of program loads black and
// goes straight to the output; one that is in program probes events one at a time
// (up to LOOKAHEAD probes through the single table read port); a fading event runs
// the bit-serial divider that rounds each of the three channels. The finished result
// moves into an output register so a new request is taken while it waits; a later
// result waits in the controller until that register is free. Table storage is a
// single RAM of 2**$clog2(MAX_EVENTS) entries, no reset; only written ones are read.
// Depends on lccp_pkg, lccp_ctrl, lccp_datapath.
module light_cue_color_player_unit #(
    parameter int MAX_EVENTS = 256,
    parameter int LOOKAHEAD  = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lccp_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output lccp_pkg::rsp_t out_data
);
    import lccp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    lccp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lccp_datapath #(.MAX_EVENTS(MAX_EVENTS), .LOOKAHEAD(LOOKAHEAD)) u_dp (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (in_data),
        .cmd  (cmd),
        .stat (stat),
        .rsp  (out_data)
    );
endmodule

/* rtl/lccp_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module lccp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* rtl/lccp_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the datapath for channel blend rounding.
module lccp_div #(
    parameter int NW = 74,
    parameter int DW = 34
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DW-1:0], quo_reg[NW-1]};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign quo  = quo_next;
endmodule

/* rtl/lccp_datapath.sv */
// Datapath: cue table, list registers, pointer search, blend and divider.
// Depends on lccp_pkg, lccp_ram, lccp_div.
module lccp_datapath #(
    parameter int MAX_EVENTS = 256,
    parameter int LOOKAHEAD  = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  lccp_pkg::req_t  req,
    input  lccp_pkg::cmd_t  cmd,
    output lccp_pkg::stat_t stat,
    output lccp_pkg::rsp_t  rsp
);
    import lccp_pkg::*;

    localparam int AW = $clog2(MAX_EVENTS);
    localparam int CNTW = $clog2(MAX_EVENTS + 1);
    localparam int LW = $clog2(LOOKAHEAD + 1);
    localparam int NW = 2 * TIME_W + 10; // 2*(255*den)+den fits
    localparam int DW = TIME_W + 2;

    req_t               req_reg;
    logic [CNTW-1:0]    count_reg;
    logic [TIME_W-1:0]  end_reg;
    logic [COLOR_W-1:0] last_reg;
    logic [AW-1:0]      ptr_reg;
    logic [AW-1:0]      probe_reg;
    logic [LW-1:0]      step_reg;
    entry_t             sel_reg;
    rsp_t               rsp_reg;
    rsp_t               out_reg;
    logic [1:0]         ch_reg;
    logic [TIME_W-1:0]  den_reg, numv_reg;
    logic [NW-1:0]      acc_reg;

    entry_t          wr_entry, rd_entry;
    logic [AW-1:0]   ram_addr;
    logic [TIME_W:0] app_sum, rd_sum;
    logic [TIME_W-1:0] rd_end, app_end;
    logic            rd_holds;
    logic [CHAN_W-1:0] ca, cb;
    logic [NW-1:0]   quo;
    logic            div_done;

    assign app_sum = {1'b0, end_reg} + {1'b0, req_reg.event_duration_ms};
    assign app_end = app_sum[TIME_W] ? '1 : app_sum[TIME_W-1:0];

    assign wr_entry = '{start: end_reg, dur: req_reg.event_duration_ms,
                        color: {req_reg.event_red, req_reg.event_green, req_reg.event_blue},
                        prior: last_reg, fade: req_reg.event_is_fade,
                        sets: req_reg.event_sets_color};
    assign ram_addr = cmd.append ? count_reg[AW-1:0] : probe_reg;

    lccp_ram #(.WIDTH(ENTRY_W), .DEPTH(2 ** AW)) u_ram (
        .clk  (clk),
        .we   (cmd.append),
        .addr (ram_addr),
        .wdata(wr_entry),
        .rdata(rd_entry)
    );

    assign rd_sum   = {1'b0, rd_entry.start} + {1'b0, rd_entry.dur};
    assign rd_end   = rd_sum[TIME_W] ? '1 : rd_sum[TIME_W-1:0];
    assign rd_holds = (req_reg.time_ms >= rd_entry.start) && (req_reg.time_ms <= rd_end);

    always_comb
    begin
        case (ch_reg)
            2'd0:    begin ca = sel_reg.prior[23:16]; cb = sel_reg.color[23:16]; end
            2'd1:    begin ca = sel_reg.prior[15:8];  cb = sel_reg.color[15:8];  end
            default: begin ca = sel_reg.prior[7:0];   cb = sel_reg.color[7:0];   end
        endcase
    end

    lccp_div #(.NW(NW), .DW(DW)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.div_start),
        .num  (acc_reg),
        .den  ({1'b0, den_reg, 1'b0}),
        .done (div_done),
        .quo  (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            end_reg   <= '0;
            last_reg  <= '0;
            ptr_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            end_reg   <= '0;
            last_reg  <= '0;
            ptr_reg   <= '0;
        end
        else if (cmd.append)
        begin
            count_reg <= count_reg + 1'b1;
            end_reg   <= app_end;
            if (req_reg.event_sets_color)
            begin
                last_reg <= wr_entry.color;
            end
        end
        else if (cmd.probe_eval && rd_holds)
        begin
            ptr_reg <= probe_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req;
            // stale pointer wraps to the first event
            probe_reg <= ({{(CNTW-AW){1'b0}}, ptr_reg} >= count_reg) ? '0 : ptr_reg;
            step_reg  <= '0;
        end
        else if (cmd.probe_next)
        begin
            probe_reg <= probe_reg + 1'b1;
            step_reg  <= step_reg + 1'b1;
        end
        if (cmd.probe_eval && (rd_holds || step_reg == '0))
        begin
            sel_reg <= rd_entry;
            den_reg <= rd_end - rd_entry.start;
            if (req_reg.time_ms <= rd_entry.start || rd_end == rd_entry.start)
            begin
                numv_reg <= '0;
            end
            else if (req_reg.time_ms - rd_entry.start > rd_end - rd_entry.start)
            begin
                numv_reg <= rd_end - rd_entry.start;
            end
            else
            begin
                numv_reg <= req_reg.time_ms - rd_entry.start;
            end
        end
        if (cmd.mul_start)
        begin
            ch_reg <= '0;
        end
        else if (cmd.ch_store)
        begin
            ch_reg <= ch_reg + 1'b1;
        end
        if (cmd.mul_step)
        begin
            acc_reg <= NW'({(NW-TIME_W-1)'(0), ca, 1'b0} * (den_reg - numv_reg))
                     + NW'({(NW-TIME_W-1)'(0), cb, 1'b0} * numv_reg)
                     + NW'(den_reg);
        end
        if (cmd.load_oop)
        begin
            rsp_reg <= '{out_red: '0, out_green: '0, out_blue: '0, out_of_program: 1'b1};
        end
        else if (cmd.load_plain)
        begin
            rsp_reg.out_of_program <= 1'b0;
            // a fade of zero length lands here and shows the prior color
            if (sel_reg.sets && !sel_reg.fade)
            begin
                {rsp_reg.out_red, rsp_reg.out_green, rsp_reg.out_blue} <= sel_reg.color;
            end
            else
            begin
                {rsp_reg.out_red, rsp_reg.out_green, rsp_reg.out_blue} <= sel_reg.prior;
            end
        end
        else if (cmd.ch_store)
        begin
            rsp_reg.out_of_program <= 1'b0;
            case (ch_reg)
                2'd0:    rsp_reg.out_red   <= quo[CHAN_W-1:0];
                2'd1:    rsp_reg.out_green <= quo[CHAN_W-1:0];
                default: rsp_reg.out_blue  <= quo[CHAN_W-1:0];
            endcase
        end
        if (cmd.emit)
        begin
            out_reg <= rsp_reg;
        end
    end

    assign stat.is_query   = req_reg.cmd == CMD_QUERY;
    assign stat.is_append  = (req_reg.cmd == CMD_APPEND) &&
                             (count_reg != CNTW'(MAX_EVENTS));
    assign stat.is_clear   = req_reg.cmd == CMD_CLEAR;
    assign stat.oop        = (count_reg == '0) || (req_reg.time_ms > end_reg);
    assign stat.hit        = rd_holds;
    assign stat.probe_last = (LW'(step_reg + 1'b1) == LW'(LOOKAHEAD)) ||
                             ({{(CNTW-AW){1'b0}}, probe_reg} + 1'b1 >= count_reg);
    assign stat.blend      = sel_reg.fade && sel_reg.sets && (den_reg != '0);
    assign stat.div_done   = div_done;
    assign stat.ch_last    = ch_reg == 2'd2;
    assign rsp             = out_reg;
endmodule

/* rtl/lccp_ctrl.sv */
// Controller state machine sequencing append, clear, search and blend.
// Depends on lccp_pkg.
module lccp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  lccp_pkg::stat_t stat,
    output lccp_pkg::cmd_t  cmd
);
    import lccp_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_EVAL  = 4'd3;
    localparam logic [3:0] S_SEL   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_WAIT  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.is_clear)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.is_append)
                begin
                    cmd.append = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!stat.is_query)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.oop)
                begin
                    cmd.load_oop = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.probe_eval = 1'b1;
                if (stat.hit || stat.probe_last)
                begin
                    state_next = S_SEL;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_RD;
                end
            end
            S_SEL:
            begin
                if (stat.blend)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
                else
                begin
                    cmd.load_plain = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.ch_store = 1'b1;
                    state_next   = stat.ch_last ? S_OUT : S_MUL;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

/* rtl/lccp_checker.sv */
// Port-level checker for the light cue color player, bound to the top level.
// Depends on lccp_pkg.
module lccp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input lccp_pkg::rsp_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_of_program |->
            out_data.out_red == 8'd0 && out_data.out_green == 8'd0 &&
            out_data.out_blue == 8'd0)
        else $error("out of program result not black");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one in work");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared with no request in work");
endmodule

bind light_cue_color_player_unit lccp_checker u_lccp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);
